// ===== hdl/isupad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISUP address digit decoder - shared types
// Payload structs for both channels, the job word passed from the front end
// to the back end, and the BCD-to-ASCII digit table.
// ----------------------------------------------------------------------------
package isupad_pkg;

  // Status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_BAD_NAT  = 2'd2;

  // Result kinds
  localparam logic RESULT_DIGIT   = 1'b0;
  localparam logic RESULT_SUMMARY = 1'b1;

  // Digit slots per byte: two prefix zeros, low nibble, high nibble
  localparam int SLOTS = 4;

  typedef struct packed {
    logic [7:0] param_byte;
    logic       first_byte;
    logic       last_byte;
    logic       with_restrict;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [6:0] digit_char;
    logic [1:0] status;
    logic       present;
    logic       restricted;
    logic       complete;
    logic [5:0] digit_total;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       present;
    logic       restricted;
    logic       complete;
  } flags_t;

  // One decoded byte: up to four digits and an optional summary
  typedef struct packed {
    logic [2:0]            ndig;
    logic [SLOTS-1:0][3:0] nib;
    logic [5:0]            base;
    flags_t                dflags;
    logic                  has_sum;
    flags_t                sflags;
  } job_t;

  localparam logic [6:0] DIGIT_ASCII [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h2E
  };

endpackage

// ===== hdl/isupad_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISUP address digit decoder - input channel
// Valid/ready channel carrying one parameter byte and its markers.
// ----------------------------------------------------------------------------
interface isupad_in_if;
  logic                 valid;
  logic                 ready;
  isupad_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/isupad_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISUP address digit decoder - output channel
// Valid/ready channel carrying one digit or summary result.
// ----------------------------------------------------------------------------
interface isupad_out_if;
  logic                  valid;
  logic                  ready;
  isupad_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/isupad_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISUP address digit decoder - front end
// Accepts parameter bytes, tracks the parse state and turns each byte into
// a job word listing the digits and summary it produces.
// ----------------------------------------------------------------------------
module isupad_front #(
  parameter int MAX_DIGITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  isupad_in_if.sink         din,
  input  logic              q_full,
  output logic              push,
  output isupad_pkg::job_t  job
);
  import isupad_pkg::*;

  typedef enum logic [1:0] {
    POS_HEAD,
    POS_PRES,
    POS_FIRST,
    POS_DIGITS
  } pos_t;

  localparam logic [6:0] NAT_SUBSCRIBER = 7'h01;
  localparam logic [6:0] NAT_UNKNOWN    = 7'h02;
  localparam logic [6:0] NAT_NATIONAL   = 7'h03;
  localparam logic [6:0] NAT_INTL       = 7'h04;
  localparam logic [6:0] NAT_SPARE      = 7'h70;
  localparam logic [1:0] PRES_RESTRICT  = 2'd1;
  localparam logic [1:0] PRES_UNAVAIL   = 2'd2;
  localparam logic [3:0] NIB_FILLER     = 4'hF;
  localparam logic [5:0] DIGIT_LIMIT    = 6'(MAX_DIGITS);

  // Parse state
  pos_t       pos, pos_next;
  logic       odd, odd_next;
  logic [6:0] nature, nature_next;
  logic [5:0] cnt, cnt_next;
  logic       stopped, stopped_next;
  flags_t     flags, flags_next;

  logic             fire;
  logic             head;
  logic [1:0]       pres_code;
  logic [SLOTS-1:0] slot_en;
  logic [3:0]       slot_nib [SLOTS];
  in_item_t         it;

  assign fire      = din.valid && din.ready;
  assign din.ready = !q_full;
  assign it        = din.data;

  // Decode one byte
  always_comb begin
    pos_next     = din.data.first_byte ? POS_HEAD : pos;
    odd_next     = odd;
    nature_next  = nature;
    cnt_next     = cnt;
    stopped_next = stopped;
    flags_next   = flags;
    head         = 1'b0;
    pres_code    = 2'd0;
    slot_en      = '0;
    for (int s = 0; s < SLOTS; s++) slot_nib[s] = 4'h0;
    job          = '0;

    unique case (pos_next)
      POS_HEAD: begin
        odd_next     = it.param_byte[7];
        nature_next  = it.param_byte[6:0];
        cnt_next     = '0;
        stopped_next = 1'b0;
        flags_next   = '0;
        head         = 1'b1;
        pos_next     = POS_PRES;
      end
      POS_PRES: begin
        pres_code             = it.with_restrict ? it.param_byte[3:2] : 2'd0;
        flags_next.present    = (pres_code != PRES_UNAVAIL);
        flags_next.restricted = (pres_code == PRES_RESTRICT);
        flags_next.complete   = (pres_code == PRES_UNAVAIL);
        pos_next              = POS_FIRST;
      end
      POS_FIRST, POS_DIGITS: begin
        if (pos_next == POS_FIRST) begin
          unique case (nature)
            NAT_SPARE, NAT_NATIONAL: ;
            NAT_SUBSCRIBER, NAT_UNKNOWN, NAT_INTL: slot_en[1:0] = 2'b11;
            default: begin
              flags_next.status = STATUS_BAD_NAT;
              stopped_next      = 1'b1;
            end
          endcase
        end
        slot_en[2]  = 1'b1;
        slot_nib[2] = it.param_byte[3:0];
        slot_en[3]  = !(it.last_byte && odd);
        slot_nib[3] = it.param_byte[7:4];
        pos_next    = POS_DIGITS;
      end
      default: ;
    endcase

    // Digit flags hold through the byte; filler only stops later digits
    job.base   = cnt_next;
    job.dflags = flags_next;

    // Walk the digit slots in order
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_en[s] && !stopped_next && (cnt_next < DIGIT_LIMIT)) begin
        if (slot_nib[s] == NIB_FILLER) begin
          flags_next.complete = 1'b1;
          stopped_next        = 1'b1;
        end else begin
          job.nib[job.ndig[1:0]] = slot_nib[s];
          job.ndig               = job.ndig + 3'd1;
          cnt_next               = cnt_next + 6'd1;
        end
      end
    end

    if (it.last_byte) begin
      if (head) flags_next.status = STATUS_SHORT;
      job.has_sum = 1'b1;
      pos_next    = POS_HEAD;
    end
    job.sflags = flags_next;
    push       = fire && ((job.ndig != 3'd0) || job.has_sum);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= POS_HEAD;
      odd     <= 1'b0;
      nature  <= '0;
      cnt     <= '0;
      stopped <= 1'b0;
      flags   <= '0;
    end else if (fire) begin
      pos     <= pos_next;
      odd     <= odd_next;
      nature  <= nature_next;
      cnt     <= cnt_next;
      stopped <= stopped_next;
      flags   <= flags_next;
    end
  end

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    cnt <= DIGIT_LIMIT) else $error("digit count past limit");
  a_last_rewinds: assert property (@(posedge clk) disable iff (rst)
    fire && din.data.last_byte |=> pos == POS_HEAD)
    else $error("last byte did not rewind parser");

endmodule

// ===== hdl/isupad_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISUP address digit decoder - job queue
// Two-entry queue of job words between the front and back ends.
// ----------------------------------------------------------------------------
module isupad_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  isupad_pkg::job_t  push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output isupad_pkg::job_t  head_job
);
  import isupad_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid)) else $error("pop from empty queue");

endmodule

// ===== hdl/isupad_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISUP address digit decoder - back end
// Takes job words and emits their digit and summary results one per cycle,
// while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module isupad_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  isupad_pkg::job_t  q_job,
  output logic              pop,
  isupad_out_if.source      dout
);
  import isupad_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic [2:0] total;
  logic       is_last;
  logic       out_free;
  logic       load_cur;
  out_item_t  res;

  assign total    = cur.ndig + 3'(cur.has_sum);
  assign is_last  = (idx == total - 3'd1);
  assign out_free = !dout.valid || dout.ready;
  assign load_cur = !cur_valid || (out_free && is_last);
  assign pop      = q_valid && load_cur;

  // Build the result for the current slot
  always_comb begin
    res = '0;
    if (idx < cur.ndig) begin
      res.result_kind = RESULT_DIGIT;
      res.digit_char  = DIGIT_ASCII[cur.nib[idx[1:0]]];
      res.status      = cur.dflags.status;
      res.present     = cur.dflags.present;
      res.restricted  = cur.dflags.restricted;
      res.complete    = cur.dflags.complete;
      res.digit_total = cur.base + 6'(idx) + 6'd1;
    end else begin
      res.result_kind = RESULT_SUMMARY;
      res.digit_char  = '0;
      res.status      = cur.sflags.status;
      res.present     = cur.sflags.present;
      res.restricted  = cur.sflags.restricted;
      res.complete    = cur.sflags.complete;
      res.digit_total = cur.base + 6'(cur.ndig);
    end
    res.run_last = is_last;
  end

  // Job register, slot counter and output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      idx        <= '0;
      dout.valid <= 1'b0;
    end else begin
      if (out_free) begin
        dout.valid <= cur_valid;
      end
      if (load_cur) begin
        cur_valid <= q_valid;
        idx       <= '0;
      end else if (out_free) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && cur_valid) dout.data <= res;
    if (load_cur) cur <= q_job;
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> idx < total) else $error("slot index past job end");

endmodule

// ===== hdl/isupad_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISUP address digit decoder - top level
// Decodes the bytes of an ISUP called/calling party number parameter into
// ASCII digits and an end-of-parameter summary.
//
//   port   dir  payload       meaning
//   din    in   in_item_t     one parameter byte with first/last markers
//   dout   out  out_item_t    one digit or summary result
//
// Each byte is decoded in the front end as it is accepted; the back end then
// emits one result per cycle unless the output stalls, at most five per byte.
// A two-entry job queue and the output register let input keep flowing
// while results wait. Reset is synchronous and clears all parse state.
// ----------------------------------------------------------------------------
module isup_address_digit_decoder_top #(
  parameter int MAX_DIGITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  isupad_in_if.sink     din,
  isupad_out_if.source  dout
);
  import isupad_pkg::*;

  logic  push;
  logic  q_full;
  logic  q_valid;
  logic  pop;
  job_t  push_job;
  job_t  q_job;

  isupad_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .din    (din),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  isupad_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_job   (q_job)
  );

  isupad_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop),
    .dout    (dout)
  );

endmodule

// ===== test/isup_address_digit_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISUP address digit decoder - testbench
// Sends directed and random number parameters through the decoder. Input
// arrives in random bursts and the output stalls on its own pattern. The
// bench keeps its own copy of the parse state and predicts every digit and
// summary result, then checks each result in order, one field at a time.
// ----------------------------------------------------------------------------
module isup_address_digit_decoder_top_tb;
  import isupad_pkg::*;

  localparam int MAX_DIGITS  = 32;
  localparam int N_BYTES     = 210;     // directed plus random requests
  localparam int HOLD_AT     = 60;      // requests taken before the long output hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_AT    = 150;     // request index at which the sender waits for a drain
  localparam int MAX_PRINTS  = 50;

  // Byte positions within one parameter
  localparam logic [1:0] POS_HEAD  = 2'd0;
  localparam logic [1:0] POS_PRES  = 2'd1;
  localparam logic [1:0] POS_FIRST = 2'd2;
  localparam logic [1:0] POS_DIGIT = 2'd3;

  // Nature of address
  localparam logic [6:0] NAT_SUBSCRIBER    = 7'h01;
  localparam logic [6:0] NAT_UNKNOWN       = 7'h02;
  localparam logic [6:0] NAT_NATIONAL      = 7'h03;
  localparam logic [6:0] NAT_INTERNATIONAL = 7'h04;
  localparam logic [6:0] NAT_SPECIAL       = 7'h70;

  // Presentation indicator
  localparam logic [1:0] PRES_ALLOWED    = 2'd0;
  localparam logic [1:0] PRES_RESTRICTED = 2'd1;
  localparam logic [1:0] PRES_NOT_AVAIL  = 2'd2;
  localparam logic [1:0] PRES_RESERVED   = 2'd3;

  // Output stall patterns
  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SLOW   = 2;
  localparam int RX_MOSTLY = 3;

  logic clk;
  logic rst = 1'b1;

  isupad_in_if  din_if ();
  isupad_out_if dout_if ();

  isup_address_digit_decoder_top #(
    .MAX_DIGITS (MAX_DIGITS)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Predicted parse state
  logic [1:0] dec_pos        = POS_HEAD;
  logic       dec_odd        = 1'b0;
  logic [6:0] dec_nature     = '0;
  logic [5:0] dec_count      = '0;
  logic       dec_stopped    = 1'b0;
  logic [1:0] dec_status     = STATUS_OK;
  logic       dec_present    = 1'b0;
  logic       dec_restricted = 1'b0;
  logic       dec_complete   = 1'b0;

  in_item_t  byte_q[$];     // requests still to send
  out_item_t result_q[$];   // predicted results, oldest first

  int   mismatches    = 0;
  int   results_seen  = 0;
  int   digits_seen   = 0;
  int   sums_seen     = 0;
  int   params_closed = 0;
  int   bytes_taken   = 0;
  int   sent_cnt      = 0;
  int   burst_left    = 1;
  int   gap_left      = 0;
  int   rx_mode       = RX_OPEN;
  int   rx_left       = 0;
  int   rx_tick       = 0;
  int   hold_left     = 0;
  logic hold_done     = 1'b0;
  logic in_taken      = 1'b0;
  int   r;
  int   wait_cyc;

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Queue one predicted result carrying the current flags
  task automatic add_result(input logic kind, input logic [6:0] ch);
    out_item_t res;
    res.result_kind = kind;
    res.digit_char  = ch;
    res.status      = dec_status;
    res.present     = dec_present;
    res.restricted  = dec_restricted;
    res.complete    = dec_complete;
    res.digit_total = dec_count;
    res.run_last    = 1'b0;
    result_q.push_back(res);
  endtask

  // One BCD nibble: filler stops the number, count saturates silently
  task automatic put_nibble(input logic [3:0] nib);
    logic [6:0] ch;
    if (dec_stopped || dec_count >= MAX_DIGITS)
      return;
    if (nib == 4'hF) begin
      dec_complete = 1'b1;
      dec_stopped  = 1'b1;
      return;
    end
    dec_count = dec_count + 6'd1;
    ch = (nib < 4'd10) ? 7'h30 + nib : 7'h41 + (nib - 4'd10);
    add_result(RESULT_DIGIT, ch);
  endtask

  // Predict the results of one accepted parameter byte
  task automatic decode_byte(input in_item_t it);
    logic       was_head;
    logic [1:0] pcode;
    int         n_before;
    out_item_t  tail;
    was_head = 1'b0;
    n_before = result_q.size();
    if (it.first_byte)
      dec_pos = POS_HEAD;
    case (dec_pos)
      POS_HEAD: begin
        dec_count      = '0;
        dec_stopped    = 1'b0;
        dec_status     = STATUS_OK;
        dec_present    = 1'b0;
        dec_restricted = 1'b0;
        dec_complete   = 1'b0;
        dec_odd        = it.param_byte[7];
        dec_nature     = it.param_byte[6:0];
        dec_pos        = POS_PRES;
        was_head       = 1'b1;
      end
      POS_PRES: begin
        pcode = it.with_restrict ? it.param_byte[3:2] : PRES_ALLOWED;
        dec_present    = (pcode != PRES_NOT_AVAIL);
        dec_restricted = (pcode == PRES_RESTRICTED);
        dec_complete   = (pcode == PRES_NOT_AVAIL);
        dec_pos        = POS_FIRST;
      end
      default: begin
        // Nature decides the prefix at the first digit byte
        if (dec_pos == POS_FIRST) begin
          case (dec_nature)
            NAT_NATIONAL, NAT_SPECIAL: ;
            NAT_SUBSCRIBER, NAT_UNKNOWN, NAT_INTERNATIONAL: begin
              put_nibble(4'h0);
              put_nibble(4'h0);
            end
            default: begin
              dec_status  = STATUS_BAD_NAT;
              dec_stopped = 1'b1;
            end
          endcase
          dec_pos = POS_DIGIT;
        end
        put_nibble(it.param_byte[3:0]);
        if (!(it.last_byte && dec_odd))
          put_nibble(it.param_byte[7:4]);
      end
    endcase
    if (it.last_byte) begin
      if (was_head)
        dec_status = STATUS_SHORT;
      add_result(RESULT_SUMMARY, 7'h00);
      dec_pos = POS_HEAD;
      params_closed++;
    end
    if (result_q.size() > n_before) begin
      tail = result_q.pop_back();
      tail.run_last = 1'b1;
      result_q.push_back(tail);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] got_v,
                             input logic [7:0] want_v);
    if (got_v !== want_v)
      flag_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                              results_seen, name, got_v, want_v));
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (got.result_kind == RESULT_SUMMARY)
      sums_seen++;
    else
      digits_seen++;
    if (result_q.size() == 0) begin
      flag_mismatch($sformatf("result %0d not expected, payload %h", results_seen, got));
      return;
    end
    want = result_q.pop_front();
    check_field("result_kind", 8'(got.result_kind), 8'(want.result_kind));
    check_field("digit_char",  8'(got.digit_char),  8'(want.digit_char));
    check_field("status",      8'(got.status),      8'(want.status));
    check_field("present",     8'(got.present),     8'(want.present));
    check_field("restricted",  8'(got.restricted),  8'(want.restricted));
    check_field("complete",    8'(got.complete),    8'(want.complete));
    check_field("digit_total", 8'(got.digit_total), 8'(want.digit_total));
    check_field("run_last",    8'(got.run_last),    8'(want.run_last));
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic first,
                            input logic last, input logic wr);
    in_item_t it;
    it.param_byte    = b;
    it.first_byte    = first;
    it.last_byte     = last;
    it.with_restrict = wr;
    byte_q.push_back(it);
  endtask

  // Digit nibble, with filler far more likely near the saturation point
  function automatic logic [3:0] pick_nibble(input int idx, input int fill_pct);
    int pct;
    pct = (idx >= 30) ? 25 : fill_pct;
    if ($urandom_range(0, 99) < pct)
      return 4'hF;
    return 4'($urandom_range(0, 14));
  endfunction

  // Well-formed parameter with random content; left open when close_it is 0
  task automatic gen_param(input int n_bytes, input logic close_it, input int fill_pct);
    logic [7:0] b;
    int         k;
    int         nib_idx;
    nib_idx = 0;
    for (k = 0; k < n_bytes; k++) begin
      if (k == 0) begin
        b[7] = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
          0:       b[6:0] = NAT_NATIONAL;
          1:       b[6:0] = NAT_SPECIAL;
          2:       b[6:0] = 7'($urandom_range(0, 127));
          default: b[6:0] = 7'($urandom_range(NAT_SUBSCRIBER, NAT_INTERNATIONAL));
        endcase
      end else if (k == 1) begin
        b = 8'($urandom_range(0, 255));
      end else begin
        b[3:0] = pick_nibble(nib_idx, fill_pct);
        b[7:4] = pick_nibble(nib_idx + 1, fill_pct);
        nib_idx += 2;
      end
      queue_byte(b, (k == 0) ? ($urandom_range(0, 3) != 0) : 1'b0,
                 close_it && (k == n_bytes - 1), 1'($urandom_range(0, 1)));
    end
  endtask

  // Monitor: take requests into the predictor, check results
  always @(posedge clk) begin
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      if (dout_if.valid && dout_if.ready)
        check_result(dout_if.data);
      in_taken = din_if.valid && din_if.ready;
      if (in_taken) begin
        decode_byte(din_if.data);
        bytes_taken++;
      end
    end
  end

  // Sender: bursts of random length with random gaps, one drain pause
  always @(negedge clk) begin
    if (rst) begin
      din_if.valid <= 1'b0;
      din_if.data  <= '0;
    end else if (!din_if.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        din_if.valid <= 1'b0;
      end else if (byte_q.size() == 0 || (sent_cnt == DRAIN_AT && result_q.size() != 0)) begin
        din_if.valid <= 1'b0;
      end else begin
        din_if.valid <= 1'b1;
        din_if.data  <= byte_q.pop_front();
        sent_cnt++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Long output hold-off, counted in cycles
  always @(posedge clk) begin
    if (!rst) begin
      if (!hold_done && bytes_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
    end
  end

  // Receiver: changing stall pattern, held off while the hold-off runs
  always @(negedge clk) begin
    if (rst) begin
      dout_if.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(RX_OPEN, RX_MOSTLY);
        rx_left = $urandom_range(10, 60);
      end else begin
        rx_left--;
      end
      rx_tick++;
      if (hold_left > 0) begin
        dout_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN: dout_if.ready <= 1'b1;
          RX_COIN: dout_if.ready <= 1'($urandom_range(0, 1));
          RX_SLOW: dout_if.ready <= (rx_tick % 4 == 0);
          default: dout_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Stimulus and end of run
  initial begin
    din_if.valid  = 1'b0;
    din_if.data   = '0;
    dout_if.ready = 1'b0;

    // Lone head byte: parameter too short
    queue_byte({1'b1, NAT_NATIONAL}, 1'b1, 1'b1, 1'b0);
    // Two bytes: unknown nature never checked, address not available
    queue_byte({1'b0, 7'h55}, 1'b1, 1'b0, 1'b1);
    queue_byte({4'h0, PRES_NOT_AVAIL, 2'b00}, 1'b0, 1'b1, 1'b1);
    // Subscriber, even, restricted: prefix then two digits
    queue_byte({1'b0, NAT_SUBSCRIBER}, 1'b1, 1'b0, 1'b0);
    queue_byte({4'h0, PRES_RESTRICTED, 2'b00}, 1'b0, 1'b0, 1'b1);
    queue_byte(8'h21, 1'b0, 1'b1, 1'b0);
    // International, odd; presentation bits ignored with decoding off
    queue_byte({1'b1, NAT_INTERNATIONAL}, 1'b1, 1'b0, 1'b1);
    queue_byte({4'hF, PRES_RESERVED, 2'b11}, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h43, 1'b0, 1'b0, 1'b1);
    queue_byte(8'hF5, 1'b0, 1'b1, 1'b1);
    // National, reserved presentation; filler drops the rest
    queue_byte({1'b0, NAT_NATIONAL}, 1'b1, 1'b0, 1'b0);
    queue_byte({4'h0, PRES_RESERVED, 2'b00}, 1'b0, 1'b0, 1'b1);
    queue_byte(8'hF9, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h77, 1'b0, 1'b1, 1'b0);
    // Special nature, odd, no prefix, letter digits
    queue_byte({1'b1, NAT_SPECIAL}, 1'b1, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0, 1'b1);
    queue_byte(8'hED, 1'b0, 1'b0, 1'b0);
    queue_byte(8'hBA, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h0C, 1'b0, 1'b1, 1'b0);
    // Unknown nature: error status, no digits
    queue_byte({1'b0, 7'h7F}, 1'b1, 1'b0, 1'b1);
    queue_byte(8'hFF, 1'b0, 1'b0, 1'b1);
    queue_byte(8'h12, 1'b0, 1'b1, 1'b0);
    // Restart in the middle of a parameter
    queue_byte({1'b0, NAT_UNKNOWN}, 1'b1, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h99, 1'b0, 1'b0, 1'b0);
    queue_byte({1'b1, NAT_SUBSCRIBER}, 1'b1, 1'b0, 1'b1);
    queue_byte({4'h0, PRES_RESTRICTED, 2'b00}, 1'b0, 1'b0, 1'b1);
    queue_byte(8'h66, 1'b0, 1'b1, 1'b0);

    // Random part: one long number first so saturation is likely to be hit
    gen_param(20, 1'b1, 1);
    while (byte_q.size() < N_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 66)
        gen_param($urandom_range(3, 8), 1'b1, 5);
      else if (r < 70)
        gen_param($urandom_range(17, 20), 1'b1, 1);
      else if (r < 80)
        gen_param($urandom_range(1, 2), 1'b1, 5);
      else if (r < 88)
        gen_param($urandom_range(1, 6), 1'b0, 5);
      else
        repeat ($urandom_range(1, 4))
          queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || din_if.valid)
      @(posedge clk);
    for (wait_cyc = 0; result_q.size() != 0 && wait_cyc < 5000; wait_cyc++)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (result_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", result_q.size()));

    $display("Run covered %0d requests in %0d closed parameters: %0d digits, %0d summaries.",
             bytes_taken, params_closed, digits_seen, sums_seen);
    $display("Included short, two-byte, bad-nature, filler, odd, restart and saturated %s",
             "numbers, bursty input, output stalls and one long hold-off.");
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("TIMEOUT: decoder run did not complete");
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/isupad_pkg.sv
hdl/isupad_in_if.sv
hdl/isupad_out_if.sv
hdl/isupad_front.sv
hdl/isupad_queue.sv
hdl/isupad_back.sv
hdl/isupad_top.sv
test/isup_address_digit_decoder_top_tb.sv
